// ===== hdl/tcc_pkg.sv =====
package tcc_pkg;

  localparam int CNT_BITS = 12;
  localparam logic [CNT_BITS-1:0] CNT_MAX = 12'hFFF;
  localparam int SAMPLE_BITS = 12;

  // opcodes of an input item
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_ARM    = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // capture modes
  localparam logic [1:0] MODE_CONT    = 2'd0;
  localparam logic [1:0] MODE_ONESHOT = 2'd1;
  localparam logic [1:0] MODE_AUTO    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_SOURCE = 3'd1;
  localparam logic [2:0] REG_WHIGH  = 3'd2;
  localparam logic [2:0] REG_WLOW   = 3'd3;
  localparam logic [2:0] REG_LENGTH = 3'd4;

  localparam logic [11:0] WHIGH_RST  = 12'd3200;
  localparam logic [11:0] WLOW_RST   = 12'd1200;
  localparam logic [11:0] LENGTH_RST = 12'd1024;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [SAMPLE_BITS-1:0] src0_a;
    logic [SAMPLE_BITS-1:0] src0_b;
    logic [SAMPLE_BITS-1:0] src1_a;
    logic [SAMPLE_BITS-1:0] src1_b;
    logic                   block_last;
  } in_item_t;

  typedef struct packed {
    logic                   word_valid;
    logic                   channel;
    logic [10:0]            word_index;
    logic [SAMPLE_BITS-1:0] word_value;
    logic                   channel_end;
    logic                   capture_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  capture_mode;
    logic        source_select;
    logic [11:0] window_high;
    logic [11:0] window_low;
    logic [11:0] capture_length;
  } cfg_t;

  typedef enum logic [1:0] {
    K_SAMPLE,
    K_READ,
    K_ARM
  } kind_t;

  // classified item handed from front to back
  typedef struct packed {
    kind_t                  kind;
    logic [SAMPLE_BITS-1:0] a;
    logic [SAMPLE_BITS-1:0] b;
    logic                   outside;
    logic                   last;
  } qitem_t;

endpackage

// ===== hdl/tcc_ram.sv =====
module tcc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tcc_front.sv =====
module tcc_front
  import tcc_pkg::*;
(
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     q_push,
  output qitem_t   q_item
);

  logic [SAMPLE_BITS-1:0] a;
  logic [SAMPLE_BITS-1:0] b;
  logic                   a_out;
  logic                   b_out;

  always_comb begin
    a = cfg.source_select ? in_data.src1_a : in_data.src0_a;
    b = cfg.source_select ? in_data.src1_b : in_data.src0_b;
    a_out = (a > cfg.window_high) || (a < cfg.window_low);
    b_out = (b > cfg.window_high) || (b < cfg.window_low);

    q_item.a       = a;
    q_item.b       = b;
    q_item.outside = a_out || b_out;
    q_item.last    = in_data.block_last;
    case (in_data.opcode)
      OP_SAMPLE: q_item.kind = K_SAMPLE;
      OP_READ:   q_item.kind = K_READ;
      OP_ARM:    q_item.kind = K_ARM;
      default:   q_item.kind = K_SAMPLE;
    endcase
  end

  assign in_stall = q_full;
  // NOP opcode is accepted and dropped here
  assign q_push   = in_valid && !q_full && (in_data.opcode != OP_NOP);

endmodule

// ===== hdl/tcc_queue.sv =====
module tcc_queue
  import tcc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qitem_t push_item,
  output logic   full,
  output logic   head_valid,
  output qitem_t head_item,
  input  logic   pop
);

  qitem_t     ent_r [2];
  logic       wp_r;
  logic       wp_nxt;
  logic       rp_r;
  logic       rp_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== hdl/tcc_back.sv =====
module tcc_back
  import tcc_pkg::*;
#(
  parameter int DEPTH = 2048
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  qitem_t    q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = $clog2(DEPTH);

  typedef enum logic {
    ST_RUN,
    ST_RDWAIT
  } state_t;

  state_t      state_r, state_nxt;
  logic [11:0] ptr_r, ptr_nxt;
  logic [11:0] off_r, off_nxt;
  logic        armed_r, armed_nxt;
  logic        trig_r, trig_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [11:0] ridx_r, ridx_nxt;
  logic        chb_r, chb_nxt;
  logic [10:0] widx_r, widx_nxt;
  logic        chend_r, chend_nxt;
  logic        capend_r, capend_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        out_free;
  logic        busy_read;
  logic [12:0] pos;
  logic [12:0] np;
  logic [11:0] ptr_sat;
  logic        pos_in;
  logic        trig_eff;
  logic        captured;
  logic [11:0] count;
  logic [11:0] idx;
  logic        last_word;
  logic        we;

  logic [SAMPLE_BITS-1:0] rdata_a;
  logic [SAMPLE_BITS-1:0] rdata_b;

  assign out_free  = !out_valid_r || !out_stall;
  // a pending read needs the output register free when issued
  assign busy_read = (q_item.kind == K_READ) && (pend_r != 2'd0) && !out_free;
  assign q_pop     = (state_r == ST_RUN) && q_valid && !busy_read;

  always_comb begin
    pos      = {1'b0, ptr_r} + {1'b0, off_r};
    np       = pos + 13'd1;
    ptr_sat  = np[12] ? CNT_MAX : np[11:0];
    pos_in   = 32'(pos) < 32'(DEPTH);
    trig_eff = trig_r ||
               ((cfg.capture_mode == MODE_AUTO) && !armed_r && q_item.outside);
    captured = (cfg.capture_mode == MODE_CONT) ||
               ((cfg.capture_mode == MODE_ONESHOT) && armed_r) ||
               ((cfg.capture_mode == MODE_AUTO) && (armed_r || trig_eff));

    count = (32'(ptr_r) < 32'(DEPTH)) ? ptr_r : 12'(DEPTH);
    if (count == 12'd0) begin
      count = 12'd1;
    end
    idx       = (ridx_r < count) ? ridx_r : count - 12'd1;
    last_word = ({1'b0, idx} + 13'd1) >= {1'b0, count};
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    off_nxt       = off_r;
    armed_nxt     = armed_r;
    trig_nxt      = trig_r;
    pend_nxt      = pend_r;
    ridx_nxt      = ridx_r;
    chb_nxt       = chb_r;
    widx_nxt      = widx_r;
    chend_nxt     = chend_r;
    capend_nxt    = capend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    we            = 1'b0;

    case (state_r)
      ST_RUN: begin
        if (q_pop) begin
          case (q_item.kind)
            K_SAMPLE: begin
              if (pend_r == 2'd0) begin
                we = pos_in;
                if (!q_item.last) begin
                  trig_nxt = trig_eff;
                  if (off_r != CNT_MAX) begin
                    off_nxt = off_r + 12'd1;
                  end
                end else begin
                  if ((cfg.capture_mode == MODE_AUTO) && trig_eff) begin
                    armed_nxt = 1'b1;
                  end
                  if (captured) begin
                    ptr_nxt = ptr_sat;
                    if (ptr_sat >= cfg.capture_length) begin
                      pend_nxt = 2'd2;
                      ridx_nxt = 12'd0;
                    end
                  end
                  off_nxt  = 12'd0;
                  trig_nxt = 1'b0;
                end
              end
            end
            K_READ: begin
              if (pend_r != 2'd0) begin
                state_nxt  = ST_RDWAIT;
                chb_nxt    = pend_r[1];
                widx_nxt   = idx[10:0];
                chend_nxt  = last_word;
                capend_nxt = last_word && !pend_r[1];
                if (!last_word) begin
                  ridx_nxt = idx + 12'd1;
                end else if (pend_r[1]) begin
                  pend_nxt = 2'd1;
                  ridx_nxt = 12'd0;
                end else begin
                  pend_nxt = 2'd0;
                  ridx_nxt = 12'd0;
                  ptr_nxt  = 12'd0;
                  if ((cfg.capture_mode == MODE_ONESHOT) ||
                      (cfg.capture_mode == MODE_AUTO)) begin
                    armed_nxt = 1'b0;
                  end
                end
              end
            end
            K_ARM: begin
              armed_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        state_nxt                = ST_RUN;
        out_valid_nxt            = 1'b1;
        out_data_nxt.word_valid  = 1'b1;
        out_data_nxt.channel     = chb_r;
        out_data_nxt.word_index  = widx_r;
        out_data_nxt.word_value  = chb_r ? rdata_b : rdata_a;
        out_data_nxt.channel_end = chend_r;
        out_data_nxt.capture_end = capend_r;
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      ptr_r       <= 12'd0;
      off_r       <= 12'd0;
      armed_r     <= 1'b0;
      trig_r      <= 1'b0;
      pend_r      <= 2'd0;
      ridx_r      <= 12'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      off_r       <= off_nxt;
      armed_r     <= armed_nxt;
      trig_r      <= trig_nxt;
      pend_r      <= pend_nxt;
      ridx_r      <= ridx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    chb_r      <= chb_nxt;
    widx_r     <= widx_nxt;
    chend_r    <= chend_nxt;
    capend_r   <= capend_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tcc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(pos)),
    .wdata (q_item.a),
    .raddr (AW'(idx)),
    .rdata (rdata_a)
  );

  tcc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(pos)),
    .wdata (q_item.b),
    .raddr (AW'(idx)),
    .rdata (rdata_b)
  );

endmodule

// ===== hdl/triggered_two_channel_capture_top.sv =====
// Sample and arm items: one per cycle sustained through the back engine while it is not serving a read item.
// Read items: registered store read, then output register; the back engine takes no new item
// until the result is in the output register.
// A two-entry queue separates input acceptance from the back engine.
// Reset is synchronous, active low: control state and config registers take their reset
// values; store contents stay undefined until written, with no clearing pass.
module triggered_two_channel_capture_top
  import tcc_pkg::*;
#(
  parameter int DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  cfg_t   cfg_r;
  cfg_t   cfg_nxt;
  logic   q_full;
  logic   q_push;
  qitem_t q_push_item;
  logic   q_valid;
  qitem_t q_head;
  logic   q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   cfg_nxt.capture_mode   = cfg_data[1:0];
        REG_SOURCE: cfg_nxt.source_select  = cfg_data[0];
        REG_WHIGH:  cfg_nxt.window_high    = cfg_data;
        REG_WLOW:   cfg_nxt.window_low     = cfg_data;
        REG_LENGTH: cfg_nxt.capture_length = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capture_mode   <= MODE_CONT;
      cfg_r.source_select  <= 1'b0;
      cfg_r.window_high    <= WHIGH_RST;
      cfg_r.window_low     <= WLOW_RST;
      cfg_r.capture_length <= LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcc_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  tcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .head_valid (q_valid),
    .head_item  (q_head),
    .pop        (q_pop)
  );

  tcc_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/triggered_two_channel_capture_top_test.sv =====
module triggered_two_channel_capture_top_test;
  import tcc_pkg::*;

  localparam int STORE_DEPTH = 2048;
  localparam int HOLD_CYCLES = 200;
  localparam int LIMIT       = 1000000;
  localparam int SETTLE      = 10;
  // mode value with no capture behavior at all
  localparam logic [1:0] MODE_IDLE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_MODE;
  logic [11:0] cfg_data = '0;

  int cycles = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  triggered_two_channel_capture_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the capture buffer: registers, stores, pointers, and the words
  // that the block still owes.
  class capture_mirror;
    logic [1:0]  mode;
    logic        src_sel;
    logic [11:0] win_hi, win_lo, cap_len;
    logic [11:0] mem_a [STORE_DEPTH];
    logic [11:0] mem_b [STORE_DEPTH];
    int ptr, offset, rd_idx, chans_left;
    bit armed, triggered;
    out_item_t due_words[$];
    int made, errors;

    function new();
      mode = MODE_CONT;
      src_sel = 1'b0;
      win_hi = WHIGH_RST;
      win_lo = WLOW_RST;
      cap_len = LENGTH_RST;
      ptr = 0;
      offset = 0;
      rd_idx = 0;
      chans_left = 0;
      armed = 0;
      triggered = 0;
      made = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [11:0] val);
      case (idx)
        REG_MODE:   mode = val[1:0];
        REG_SOURCE: src_sel = val[0];
        REG_WHIGH:  win_hi = val;
        REG_WLOW:   win_lo = val;
        REG_LENGTH: cap_len = val;
        default: ;
      endcase
    endfunction

    function bit outside(int v);
      return v > win_hi || v < win_lo;
    endfunction

    function void take_item(in_item_t it);
      int a, b, pos, np, cnt, idx;
      bit hit, last, chb;
      out_item_t w;
      case (it.opcode)
        OP_SAMPLE: if (chans_left == 0) begin
          a = src_sel ? it.src1_a : it.src0_a;
          b = src_sel ? it.src1_b : it.src0_b;
          if (mode == MODE_AUTO && !armed && (outside(a) || outside(b)))
            triggered = 1;
          pos = ptr + offset;
          if (pos < STORE_DEPTH) begin
            mem_a[pos] = a;
            mem_b[pos] = b;
          end
          if (!it.block_last) begin
            if (offset < CNT_MAX) offset++;
          end else begin
            hit = mode == MODE_CONT || (mode == MODE_ONESHOT && armed) ||
                  (mode == MODE_AUTO && (armed || triggered));
            if (mode == MODE_AUTO && triggered) armed = 1;
            if (hit) begin
              np = ptr + offset + 1;
              ptr = np > CNT_MAX ? CNT_MAX : np;
              if (ptr >= cap_len) begin
                chans_left = 2;
                rd_idx = 0;
              end
            end
            offset = 0;
            triggered = 0;
          end
        end
        OP_READ: if (chans_left != 0) begin
          cnt = ptr < STORE_DEPTH ? ptr : STORE_DEPTH;
          if (cnt == 0) cnt = 1;
          idx = rd_idx < cnt ? rd_idx : cnt - 1;
          chb = chans_left >= 2;
          last = idx + 1 >= cnt;
          w.word_valid = 1'b1;
          w.channel = chb;
          w.word_index = 11'(idx);
          w.word_value = chb ? mem_b[idx] : mem_a[idx];
          w.channel_end = last;
          w.capture_end = last && !chb;
          due_words.push_back(w);
          made++;
          if (!last) begin
            rd_idx = idx + 1;
          end else if (chb) begin
            chans_left = 1;
            rd_idx = 0;
          end else begin
            chans_left = 0;
            rd_idx = 0;
            ptr = 0;
            if (mode == MODE_ONESHOT || mode == MODE_AUTO) armed = 0;
          end
        end
        OP_ARM: armed = 1;
        default: ;
      endcase
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (due_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: ch %0d idx %0d val %0d", got.channel,
                   got.word_index, got.word_value);
        return;
      end
      want = due_words.pop_front();
      if (got.word_valid !== want.word_valid || got.channel !== want.channel ||
          got.word_index !== want.word_index || got.word_value !== want.word_value ||
          got.channel_end !== want.channel_end ||
          got.capture_end !== want.capture_end) begin
        errors++;
        if (errors <= 10) begin
          $display("word mismatch: exp v%0d ch%0d idx%0d val%0d ce%0d ke%0d",
                   want.word_valid, want.channel, want.word_index, want.word_value,
                   want.channel_end, want.capture_end);
          $display("               got v%0d ch%0d idx%0d val%0d ce%0d ke%0d",
                   got.word_valid, got.channel, got.word_index, got.word_value,
                   got.channel_end, got.capture_end);
        end
      end
    endfunction
  endclass

  capture_mirror mirror;

  always #4 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) mirror.take_item(in_data);
      if (out_valid && !out_stall) mirror.check_word(out_data);
    end
  end

  // result side back-pressure; a hold-off request stalls for a long stretch
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < out_stall_pct;
    end
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("simulation failed");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [11:0] a0, b0, a1, b1,
                         input logic last);
    in_item_t it;
    it.opcode = op;
    it.src0_a = a0;
    it.src0_b = b0;
    it.src1_a = a1;
    it.src1_b = b1;
    it.block_last = last;
    send_item(it);
  endtask

  task automatic read_out();
    while (mirror.chans_left != 0)
      send_op(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (mirror.due_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic src,
                            input logic [11:0] hi, lo, len);
    logic [2:0]  regs [5];
    logic [11:0] vals [5];
    regs = '{REG_MODE, REG_SOURCE, REG_WHIGH, REG_WLOW, REG_LENGTH};
    vals = '{{10'd0, mode}, {11'd0, src}, hi, lo, len};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      mirror.write_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic start_phase(input int idle, input int stall, input bit hold);
    @(posedge clk);
    in_idle_pct = idle;
    out_stall_pct = stall;
    if (hold) hold_req++;
    @(negedge clk);
  endtask

  function automatic logic [11:0] window_pick();
    case ($urandom_range(3))
      0: return 12'd0;
      1: return 12'd4095;
      default: return $urandom;
    endcase
  endfunction

  // sample levels cluster around the window edges
  function automatic logic [11:0] pick_level();
    case ($urandom_range(9))
      0: return mirror.win_lo - 12'd1;
      1: return mirror.win_lo;
      2: return mirror.win_hi;
      3: return mirror.win_hi + 12'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config();
    set_config($urandom_range(MODE_AUTO), $urandom, window_pick(), window_pick(),
               $urandom_range(1, 10));
  endtask

  // mostly well-formed blocks and full readouts, with some noise mixed in
  task automatic run_random(input int n);
    int useful, base, r;
    in_item_t it;
    useful = 0;
    base = mirror.made;
    while (useful < n || mirror.made - base < 30) begin
      it.src0_a = pick_level();
      it.src0_b = pick_level();
      it.src1_a = pick_level();
      it.src1_b = pick_level();
      it.block_last = $urandom_range(3) == 0;
      it.opcode = $urandom;
      r = $urandom_range(99);
      if (mirror.chans_left != 0) begin
        if (r < 85) begin
          it.opcode = OP_READ;
          useful++;
        end
      end else if (r < 78) begin
        it.opcode = OP_SAMPLE;
        useful++;
      end else if (r < 84) begin
        it.opcode = OP_ARM;
        useful++;
      end else if (it.opcode != OP_NOP) begin
        it.opcode = OP_READ;
      end
      send_item(it);
    end
  endtask

  initial begin
    mirror = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    start_phase(0, 0, 0);
    set_config(MODE_AUTO, 1'b1, 12'd3000, 12'd1000, 12'd2);
    send_op(OP_READ, 0, 0, 0, 0, 1);           // nothing pending
    send_op(OP_NOP, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1);
    // unselected source out of window: no trigger, block dropped
    send_op(OP_SAMPLE, 0, 4095, 1500, 2500, 1);
    send_op(OP_SAMPLE, 2000, 2000, 999, 2000, 0);
    send_op(OP_SAMPLE, 0, 0, 1000, 3000, 1);
    send_op(OP_SAMPLE, 1, 2, 3, 4, 1);         // ignored during readout
    read_out();
    send_op(OP_SAMPLE, 0, 0, 2000, 3001, 1);
    send_op(OP_SAMPLE, 0, 0, 2000, 2000, 1);   // armed, captured without trigger
    read_out();
    settle();

    set_config(MODE_ONESHOT, 1'b1, 12'd3000, 12'd1000, 12'd2);
    send_op(OP_SAMPLE, 5, 6, 7, 8, 1);         // not armed: dropped
    send_op(OP_ARM, 0, 0, 0, 0, 0);
    send_op(OP_SAMPLE, 9, 10, 11, 12, 1);
    send_op(OP_SAMPLE, 13, 14, 15, 16, 1);
    read_out();
    settle();

    set_config(MODE_IDLE, 1'b0, 12'd4095, 12'd0, 12'd1);
    send_op(OP_SAMPLE, 1, 1, 1, 1, 1);
    send_op(OP_ARM, 0, 0, 0, 0, 0);
    send_op(OP_SAMPLE, 2, 2, 2, 2, 1);
    settle();

    set_config(MODE_CONT, 1'b0, 12'd4095, 12'd0, 12'd1);
    send_op(OP_SAMPLE, 0, 4095, 4095, 0, 0);
    send_op(OP_SAMPLE, 4095, 0, 0, 4095, 1);
    read_out();
    settle();

    random_config();
    run_random(70);
    settle();

    start_phase(74, 0, 0);
    random_config();
    run_random(70);
    settle();

    start_phase(0, 74, 1);
    random_config();
    run_random(70);
    settle();

    start_phase(24, 24, 0);
    random_config();
    run_random(70);
    settle();

    // inverted window: every sample lies outside
    start_phase(0, 0, 0);
    set_config(MODE_AUTO, $urandom, 12'd0, 12'd4095, $urandom_range(1, 10));
    run_random(70);
    settle();

    if (mirror.errors == 0 && mirror.due_words.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
